>>> sv/swr_pkg.sv
package swr_pkg;

    localparam int PAYLOAD_MAX = 32;
    localparam int PL_W        = 6;
    localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int IDX_W       = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int SUM_W       = IDX_W + 8;
    localparam int LEN_W       = 32;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_NACK = 2'd1;
    localparam logic [1:0] KIND_BYTE = 2'd2;

    // response job handed from front to back
    typedef struct packed {
        logic             is_ack;
        logic             done;
        logic [LEN_W-1:0] msg_len;
        logic [CNT_W-1:0] count;
        logic             bank;
    } t_job;

    // store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // bank release from back to front
    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

endpackage

>>> sv/swr_if.sv
interface swr_in_if;
    import swr_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [7:0]          payload_byte;
    logic [PL_W-1:0]     pkt_len;
    logic signed [31:0]  claimed_checksum;
    logic                is_last_packet;

    modport source (output valid, func, payload_byte, pkt_len,
                    claimed_checksum, is_last_packet, input ready);
    modport sink   (input valid, func, payload_byte, pkt_len,
                    claimed_checksum, is_last_packet, output ready);
endinterface

interface swr_out_if;
    import swr_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       result_kind;
    logic [7:0]       data_byte;
    logic             message_done;
    logic [LEN_W-1:0] message_length;
    logic             run_last;

    modport source (output valid, result_kind, data_byte, message_done,
                    message_length, run_last, input ready);
    modport sink   (input valid, result_kind, data_byte, message_done,
                    message_length, run_last, output ready);
endinterface

>>> sv/swr_fifo.sv
module swr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  swr_pkg::t_job i_data,
    input  logic          i_pop,
    output swr_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import swr_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CT_W  = $clog2(QDEPTH + 1);

    t_job             r_q [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CT_W-1:0]  r_cnt;

    function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    assign o_full  = (r_cnt == CT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= inc(r_wr);
            if (i_pop)  r_rd <= inc(r_rd);
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

>>> sv/swr_front.sv
module swr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swr_in_if.sink        i_in,
    output logic          o_push,
    output swr_pkg::t_job o_job,
    input  logic          i_full,
    output swr_pkg::t_wr  o_wr,
    input  swr_pkg::t_rel i_rel
);
    import swr_pkg::*;

    logic                    r_pend, n_pend;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic [CNT_W-1:0]        r_exp, n_exp;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [31:0]             r_chk, n_chk;
    logic                    r_last, n_last;
    logic [LEN_W-1:0]        r_total, n_total;
    logic                    r_wbank, n_wbank;
    logic [1:0]              r_busy, n_busy;

    logic                    accept;
    logic [CNT_W-1:0]        len_c;
    logic                    fin;
    logic signed [SUM_W-1:0] f_sum;
    logic [31:0]             f_chk;
    logic                    f_last;
    logic [CNT_W-1:0]        f_len;
    logic                    match;
    logic [LEN_W:0]          sat;
    logic [LEN_W-1:0]        tot;

    assign i_in.ready = !i_full && !r_busy[r_wbank];
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_in.pkt_len > PL_W'(PAYLOAD_MAX)) len_c = CNT_W'(PAYLOAD_MAX);
        else len_c = i_in.pkt_len[CNT_W-1:0];
    end

    always_comb begin
        n_pend  = r_pend;
        n_seen  = r_seen;
        n_exp   = r_exp;
        n_sum   = r_sum;
        n_chk   = r_chk;
        n_last  = r_last;
        n_total = r_total;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_job   = '0;
        o_wr    = '0;
        fin     = 1'b0;
        f_sum   = '0;
        f_chk   = r_chk;
        f_last  = r_last;
        f_len   = r_exp;
        match   = 1'b0;
        sat     = '0;
        tot     = '0;

        if (i_rel.en) n_busy[i_rel.bank] = 1'b0;

        if (accept) begin
            if (!i_in.func) begin
                // header restarts the packet, open or not
                n_chk  = i_in.claimed_checksum;
                n_last = i_in.is_last_packet;
                n_exp  = len_c;
                n_seen = '0;
                n_sum  = '0;
                n_pend = 1'b1;
                if (len_c == '0) begin
                    fin    = 1'b1;
                    f_chk  = i_in.claimed_checksum;
                    f_last = i_in.is_last_packet;
                    f_len  = '0;
                end
            end else if (r_pend) begin
                o_wr.en   = 1'b1;
                o_wr.addr = {r_wbank, r_seen[IDX_W-1:0]};
                o_wr.data = i_in.payload_byte;
                n_sum  = r_sum + {{(SUM_W-8){i_in.payload_byte[7]}}, i_in.payload_byte};
                n_seen = r_seen + 1'b1;
                if (n_seen >= r_exp) begin
                    fin   = 1'b1;
                    f_sum = n_sum;
                end
            end
        end

        if (fin) begin
            n_pend = 1'b0;
            o_push = 1'b1;
            match  = ({{(32-SUM_W){f_sum[SUM_W-1]}}, f_sum} == f_chk);
            if (!match) begin
                o_job.is_ack  = 1'b0;
                o_job.msg_len = r_total;
            end else begin
                sat = {1'b0, r_total} + (LEN_W+1)'(f_len);
                tot = sat[LEN_W] ? '1 : sat[LEN_W-1:0];
                o_job.is_ack  = 1'b1;
                o_job.done    = f_last;
                o_job.msg_len = tot;
                o_job.count   = f_len;
                o_job.bank    = r_wbank;
                n_total = f_last ? '0 : tot;
                if (f_len != '0) begin
                    // bank now belongs to the back until drained
                    n_busy[r_wbank] = 1'b1;
                    n_wbank = ~r_wbank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_seen  <= '0;
            r_exp   <= '0;
            r_sum   <= '0;
            r_chk   <= '0;
            r_last  <= 1'b0;
            r_total <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_pend  <= n_pend;
            r_seen  <= n_seen;
            r_exp   <= n_exp;
            r_sum   <= n_sum;
            r_chk   <= n_chk;
            r_last  <= n_last;
            r_total <= n_total;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

>>> sv/swr_back.sv
module swr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  swr_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    input  swr_pkg::t_wr  i_wr,
    output swr_pkg::t_rel o_rel,
    swr_out_if.source     o_res
);
    import swr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_BYTE = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             done;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_result;

    logic [7:0]       r_mem [2*PAYLOAD_MAX];
    logic [7:0]       r_rdata;

    logic [1:0]       r_state, n_state;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    t_result          r_out, n_out;

    logic             take, free, load, is_end;

    // packet store, two banks
    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
        r_rdata <= r_mem[{r_bank, r_idx[IDX_W-1:0]}];
    end

    assign take   = r_ovalid && o_res.ready;
    assign free   = !r_ovalid || take;
    assign is_end = (r_idx + 1'b1 == r_cnt);

    always_comb begin
        n_state = r_state;
        n_bank  = r_bank;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_out   = r_out;
        o_pop   = 1'b0;
        o_rel   = '0;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty && free) begin
                    o_pop      = 1'b1;
                    load       = 1'b1;
                    n_out.kind = i_job.is_ack ? KIND_ACK : KIND_NACK;
                    n_out.data = '0;
                    n_out.done = i_job.is_ack && i_job.done;
                    n_out.len  = i_job.msg_len;
                    n_out.last = !i_job.is_ack || (i_job.count == '0);
                    if (i_job.is_ack && i_job.count != '0) begin
                        n_bank  = i_job.bank;
                        n_idx   = '0;
                        n_cnt   = i_job.count;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_BYTE;
            S_BYTE: begin
                if (free) begin
                    load       = 1'b1;
                    n_out.kind = KIND_BYTE;
                    n_out.data = r_rdata;
                    n_out.done = 1'b0;
                    n_out.len  = '0;
                    n_out.last = is_end;
                    if (is_end) begin
                        o_rel.en   = 1'b1;
                        o_rel.bank = r_bank;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = load ? 1'b1 : (take ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bank   <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.result_kind    = r_out.kind;
    assign o_res.data_byte      = r_out.data;
    assign o_res.message_done   = r_out.done;
    assign o_res.message_length = r_out.len;
    assign o_res.run_last       = r_out.last;

endmodule

>>> sv/stop_and_wait_receiver.sv
// Channel  Dir  Handshake     Item
// i_in     in   valid/ready   header (checksum, length, last flag) or payload byte
// o_res    out  valid/ready   ACK, NACK or delivered payload byte
//
// Input: one item per cycle while not stalled; headers and bytes alike.
// Output: each delivered byte passes through states S_RD and S_BYTE (store read
// port is registered, one read per byte).
// Input stalls when the job queue (two entries) is full, or when the store
// bank the next packet would fill is still being drained.
// Reset: synchronous, active low; the store itself is not cleared.
module stop_and_wait_receiver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swr_in_if.sink    i_in,
    swr_out_if.source o_res
);
    import swr_pkg::*;

    // front -> queue -> back
    logic push, pop, full, empty;
    t_job job_in, job_out;
    t_wr  wr;       // byte writes into the two-bank store
    t_rel rel;      // back hands a drained bank back to the front

    // classify items, keep checksum state, fill the store
    swr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full),
        .o_wr    (wr),
        .i_rel   (rel)
    );

    // response jobs, in packet order
    swr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    // emit ACK/NACK, then drain the packet's bytes
    swr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .i_wr    (wr),
        .o_rel   (rel),
        .o_res   (o_res)
    );

endmodule
